### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Both macros sample on the rising edge of clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### sv/bvhmp_pkg.sv
package bvhmp_pkg;

	// Store geometry.
	localparam int MAX_TRIANGLES = 1024;
	localparam int SLOT_BITS     = $clog2(MAX_TRIANGLES);
	localparam int COUNT_BITS    = $clog2(MAX_TRIANGLES + 1);
	localparam int ENTRY_BITS    = SLOT_BITS + 1;

	// Field widths.
	localparam int COORD_BITS  = 32;
	localparam int CFG_BITS    = 32;
	localparam int LEVEL_BITS  = 9;
	localparam int BASE_BITS   = 20;
	localparam int IDX_BITS    = 21;
	localparam int REG_IDX_BITS = 3;

	// The shared adder holds 2*(A+B+C) - 3*(min+max) without overflow.
	localparam int ALU_W = COORD_BITS + 4;

	typedef logic [ALU_W-1:0] alu_t;

	// Operation codes.
	localparam logic [1:0] OP_LOAD      = 2'd0;
	localparam logic [1:0] OP_PARTITION = 2'd1;
	localparam logic [1:0] OP_READ      = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_LOADED   = 3'd0;
	localparam logic [2:0] ST_SPLIT    = 3'd1;
	localparam logic [2:0] ST_NO_DEPTH = 3'd2;
	localparam logic [2:0] ST_TOO_FEW  = 3'd3;
	localparam logic [2:0] ST_ONE_SIDE = 3'd4;
	localparam logic [2:0] ST_INDEX    = 3'd5;
	localparam logic [2:0] ST_REJECTED = 3'd6;

	// Axis codes.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_X  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_Y  = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_Z  = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX_X  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX_Y  = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX_Z  = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_LEVELS = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_BASE   = 3'd7;

	// Sign-extend a coordinate to the adder width.
	function automatic alu_t sx(input logic [COORD_BITS-1:0] v);
		return {{(ALU_W-COORD_BITS){v[COORD_BITS-1]}}, v};
	endfunction

endpackage

### sv/bvh_midpoint_partition_top.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    operation, ax..cz
// out       output     out_valid / out_ready  status, slot_count, left_count, right_count,
//                                             axis, tri_index
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every item first runs five steps of the shared adder to pick the longest axis. A load
// then takes five more adder steps before the issue state. A read fetches its slot and
// adds the base index; a rejected or stopped item skips to the issue state. A partition
// passes S_P_CHK and S_P_EVAL for a left triangle, plus S_P_SWAP for a right one, as the
// slot store has one write port. arst_n clears counts, phase and configuration; the store
// itself is not cleared. A stalled result waits in the output register while the next
// item is accepted; a finished item holds in the issue state until it is free.
`include "assert_macros.svh"

module bvh_midpoint_partition_top import bvhmp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic [COORD_BITS-1:0]    ax,
	input  logic [COORD_BITS-1:0]    ay,
	input  logic [COORD_BITS-1:0]    az,
	input  logic [COORD_BITS-1:0]    bx,
	input  logic [COORD_BITS-1:0]    by_coord,
	input  logic [COORD_BITS-1:0]    bz,
	input  logic [COORD_BITS-1:0]    cx,
	input  logic [COORD_BITS-1:0]    cy,
	input  logic [COORD_BITS-1:0]    cz,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               status,
	output logic [COUNT_BITS-1:0]    slot_count,
	output logic [COUNT_BITS-1:0]    left_count,
	output logic [COUNT_BITS-1:0]    right_count,
	output logic [1:0]               axis,
	output logic [IDX_BITS-1:0]      tri_index,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [REG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]      cfg_data
);

	typedef enum logic [16:0] {
		S_IDLE   = 17'b00000000000000001,
		S_AX_DX  = 17'b00000000000000010,
		S_AX_DY  = 17'b00000000000000100,
		S_AX_DZ  = 17'b00000000000001000,
		S_AX_C1  = 17'b00000000000010000,
		S_AX_C2  = 17'b00000000000100000,
		S_L_SUM1 = 17'b00000000001000000,
		S_L_SUM2 = 17'b00000000010000000,
		S_L_BND  = 17'b00000000100000000,
		S_L_TRI  = 17'b00000001000000000,
		S_L_CMP  = 17'b00000010000000000,
		S_P_CHK  = 17'b00000100000000000,
		S_P_EVAL = 17'b00001000000000000,
		S_P_SWAP = 17'b00010000000000000,
		S_R_RD   = 17'b00100000000000000,
		S_R_IDX  = 17'b01000000000000000,
		S_EMIT   = 17'b10000000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [COORD_BITS-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;
	logic [LEVEL_BITS-1:0] levels_q;
	logic [BASE_BITS-1:0]  base_q;

	// Captured item.
	logic [1:0]            op_q;
	logic [COORD_BITS-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;

	// Node state.
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] rp_q;
	logic                  phase_q;

	// Working registers of the sequencer.
	alu_t                  t0_q, t1_q, t2_q;
	logic                  gt_q;
	logic [1:0]            axis_q;
	logic [COUNT_BITS-1:0] i_q, j_q;
	logic [ENTRY_BITS-1:0] hold_q;

	// Pending result.
	logic [2:0]            res_status_q;
	logic [COUNT_BITS-1:0] res_left_q, res_right_q;
	logic [IDX_BITS-1:0]   res_idx_q;

	// Output register.
	logic                  out_valid_q;
	logic [2:0]            out_status_q;
	logic [COUNT_BITS-1:0] out_slot_q, out_left_q, out_right_q;
	logic [1:0]            out_axis_q;
	logic [IDX_BITS-1:0]   out_idx_q;

	// Slot store: side bit on top of the slot number.
	logic [ENTRY_BITS-1:0] store_q [MAX_TRIANGLES];
	logic [ENTRY_BITS-1:0] rd_a_q, rd_b_q;
	logic [SLOT_BITS-1:0]  rd_a_addr, rd_b_addr, wr_addr;
	logic [ENTRY_BITS-1:0] wr_data;
	logic                  wr_en;

	// Shared adder.
	alu_t alu_a, alu_b, alu_b_eff, alu_r;
	logic alu_sub;

	logic                  in_beat;
	logic                  out_free;
	logic                  axis_next;
	logic [1:0]            axis_sel;
	logic [COORD_BITS-1:0] sel_a, sel_b, sel_c, sel_min, sel_max;
	logic [COUNT_BITS-1:0] load_slot;
	logic [COUNT_BITS-1:0] j_dec;
	logic                  no_depth;

	assign in_ready  = (state_q == S_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign slot_count  = out_slot_q;
	assign left_count  = out_left_q;
	assign right_count = out_right_q;
	assign axis        = out_axis_q;
	assign tri_index   = out_idx_q;

	assign load_slot = phase_q ? '0 : count_q;
	assign j_dec     = j_q - COUNT_BITS'(1);
	assign no_depth  = levels_q[LEVEL_BITS-1] || (levels_q == '0);
	assign axis_next = alu_r[ALU_W-1];

	// Coordinates on the chosen axis.
	assign axis_sel = axis_q;
	always_comb begin
		case (axis_sel)
			AXIS_X: begin
				sel_a = ax_q; sel_b = bx_q; sel_c = cx_q;
				sel_min = min_x_q; sel_max = max_x_q;
			end
			AXIS_Y: begin
				sel_a = ay_q; sel_b = by_q; sel_c = cy_q;
				sel_min = min_y_q; sel_max = max_y_q;
			end
			default: begin
				sel_a = az_q; sel_b = bz_q; sel_c = cz_q;
				sel_min = min_z_q; sel_max = max_z_q;
			end
		endcase
	end

	// Operand selection of the shared adder for each sequencer step.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_AX_DX: begin
				alu_a = sx(max_x_q); alu_b = sx(min_x_q); alu_sub = 1'b1;
			end
			S_AX_DY: begin
				alu_a = sx(max_y_q); alu_b = sx(min_y_q); alu_sub = 1'b1;
			end
			S_AX_DZ: begin
				alu_a = sx(max_z_q); alu_b = sx(min_z_q); alu_sub = 1'b1;
			end
			S_AX_C1: begin
				alu_a = t1_q; alu_b = t0_q; alu_sub = 1'b1;
			end
			S_AX_C2: begin
				alu_a = t2_q; alu_b = gt_q ? t0_q : t1_q; alu_sub = 1'b1;
			end
			S_L_SUM1: begin
				alu_a = sx(sel_a); alu_b = sx(sel_b);
			end
			S_L_SUM2: begin
				alu_a = t0_q; alu_b = sx(sel_c);
			end
			S_L_BND: begin
				alu_a = sx(sel_min); alu_b = sx(sel_max);
			end
			S_L_TRI: begin
				alu_a = t1_q; alu_b = {t1_q[ALU_W-2:0], 1'b0};
			end
			S_L_CMP: begin
				alu_a = {t0_q[ALU_W-2:0], 1'b0}; alu_b = t1_q; alu_sub = 1'b1;
			end
			S_R_IDX: begin
				alu_a = {{(ALU_W-BASE_BITS){1'b0}}, base_q};
				alu_b = {{(ALU_W-SLOT_BITS){1'b0}}, rd_a_q[SLOT_BITS-1:0]};
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
	assign alu_r     = alu_a + alu_b_eff + {{(ALU_W-1){1'b0}}, alu_sub};

	// Store port control: loads and the two halves of a swap share one write port.
	always_comb begin
		rd_a_addr = (state_q == S_R_RD) ? rp_q[SLOT_BITS-1:0] : i_q[SLOT_BITS-1:0];
		rd_b_addr = j_dec[SLOT_BITS-1:0];
		wr_en     = 1'b0;
		wr_addr   = i_q[SLOT_BITS-1:0];
		wr_data   = rd_b_q;
		unique case (state_q)
			S_L_CMP: begin
				wr_en   = 1'b1;
				wr_addr = load_slot[SLOT_BITS-1:0];
				wr_data = {alu_r[ALU_W-1], load_slot[SLOT_BITS-1:0]};
			end
			S_P_EVAL: begin
				wr_en   = !rd_a_q[SLOT_BITS];
				wr_addr = i_q[SLOT_BITS-1:0];
				wr_data = rd_b_q;
			end
			S_P_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = j_dec[SLOT_BITS-1:0];
				wr_data = hold_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Slot store with registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_a_q <= store_q[rd_a_addr];
		rd_b_q <= store_q[rd_b_addr];
	end

	// Item capture; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q <= operation;
			ax_q <= ax; ay_q <= ay; az_q <= az;
			bx_q <= bx; by_q <= by_coord; bz_q <= bz;
			cx_q <= cx; cy_q <= cy; cz_q <= cz;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q  <= '0;
			min_y_q  <= '0;
			min_z_q  <= '0;
			max_x_q  <= '0;
			max_y_q  <= '0;
			max_z_q  <= '0;
			levels_q <= '0;
			base_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_X:  min_x_q  <= cfg_data[COORD_BITS-1:0];
				REG_MIN_Y:  min_y_q  <= cfg_data[COORD_BITS-1:0];
				REG_MIN_Z:  min_z_q  <= cfg_data[COORD_BITS-1:0];
				REG_MAX_X:  max_x_q  <= cfg_data[COORD_BITS-1:0];
				REG_MAX_Y:  max_y_q  <= cfg_data[COORD_BITS-1:0];
				REG_MAX_Z:  max_z_q  <= cfg_data[COORD_BITS-1:0];
				REG_LEVELS: levels_q <= cfg_data[LEVEL_BITS-1:0];
				REG_BASE:   base_q   <= cfg_data[BASE_BITS-1:0];
				default:    base_q   <= base_q;
			endcase
		end
	end

	// Sequencer, node state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rp_q         <= '0;
			phase_q      <= 1'b0;
			t0_q         <= '0;
			t1_q         <= '0;
			t2_q         <= '0;
			gt_q         <= 1'b0;
			axis_q       <= AXIS_X;
			i_q          <= '0;
			j_q          <= '0;
			hold_q       <= '0;
			res_status_q <= ST_REJECTED;
			res_left_q   <= '0;
			res_right_q  <= '0;
			res_idx_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_REJECTED;
			out_slot_q   <= '0;
			out_left_q   <= '0;
			out_right_q  <= '0;
			out_axis_q   <= AXIS_X;
			out_idx_q    <= '0;
		end else begin
			// The result beat leaves on out_ready unless a new one replaces it.
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_AX_DX;
					end
				end

				// Extents of the bounds, then the two compares of the axis choice.
				S_AX_DX: begin
					t0_q    <= alu_r;
					state_q <= S_AX_DY;
				end
				S_AX_DY: begin
					t1_q    <= alu_r;
					state_q <= S_AX_DZ;
				end
				S_AX_DZ: begin
					t2_q    <= alu_r;
					state_q <= S_AX_C1;
				end
				S_AX_C1: begin
					gt_q    <= alu_r[ALU_W-1];
					state_q <= S_AX_C2;
				end
				S_AX_C2: begin
					if (axis_next) begin
						axis_q <= gt_q ? AXIS_X : AXIS_Y;
					end else begin
						axis_q <= AXIS_Z;
					end
					res_left_q   <= '0;
					res_right_q  <= '0;
					res_idx_q    <= '0;
					unique case (op_q)
						OP_LOAD: begin
							res_status_q <= ST_REJECTED;
							if (phase_q || (count_q != COUNT_BITS'(MAX_TRIANGLES))) begin
								state_q <= S_L_SUM1;
							end else begin
								state_q <= S_EMIT;
							end
						end
						OP_PARTITION: begin
							if (no_depth) begin
								res_status_q <= ST_NO_DEPTH;
								phase_q      <= 1'b1;
								rp_q         <= '0;
								state_q      <= S_EMIT;
							end else if (count_q <= COUNT_BITS'(2)) begin
								res_status_q <= ST_TOO_FEW;
								phase_q      <= 1'b1;
								rp_q         <= '0;
								state_q      <= S_EMIT;
							end else begin
								res_status_q <= ST_REJECTED;
								i_q          <= '0;
								j_q          <= count_q;
								state_q      <= S_P_CHK;
							end
						end
						OP_READ: begin
							res_status_q <= ST_REJECTED;
							if (phase_q && (rp_q < count_q)) begin
								state_q <= S_R_RD;
							end else begin
								state_q <= S_EMIT;
							end
						end
						default: begin
							res_status_q <= ST_REJECTED;
							state_q      <= S_EMIT;
						end
					endcase
				end

				// Load: 2*(A+B+C) against 3*(min+max) on the chosen axis.
				S_L_SUM1: begin
					t0_q    <= alu_r;
					state_q <= S_L_SUM2;
				end
				S_L_SUM2: begin
					t0_q    <= alu_r;
					state_q <= S_L_BND;
				end
				S_L_BND: begin
					t1_q    <= alu_r;
					state_q <= S_L_TRI;
				end
				S_L_TRI: begin
					t1_q    <= alu_r;
					state_q <= S_L_CMP;
				end
				S_L_CMP: begin
					count_q      <= load_slot + COUNT_BITS'(1);
					rp_q         <= '0;
					phase_q      <= 1'b0;
					res_status_q <= ST_LOADED;
					state_q      <= S_EMIT;
				end

				// Two-pointer partition: left entries stay, right ones swap to the back.
				S_P_CHK: begin
					if (i_q < j_q) begin
						state_q <= S_P_EVAL;
					end else begin
						res_left_q  <= i_q;
						res_right_q <= count_q - i_q;
						if ((i_q == '0) || (i_q == count_q)) begin
							res_status_q <= ST_ONE_SIDE;
						end else begin
							res_status_q <= ST_SPLIT;
						end
						phase_q <= 1'b1;
						rp_q    <= '0;
						state_q <= S_EMIT;
					end
				end
				S_P_EVAL: begin
					if (rd_a_q[SLOT_BITS]) begin
						i_q     <= i_q + COUNT_BITS'(1);
						state_q <= S_P_CHK;
					end else begin
						hold_q  <= rd_a_q;
						state_q <= S_P_SWAP;
					end
				end
				S_P_SWAP: begin
					j_q     <= j_dec;
					state_q <= S_P_CHK;
				end

				// Read: fetch the slot at the read pointer and add the base index.
				S_R_RD: begin
					state_q <= S_R_IDX;
				end
				S_R_IDX: begin
					res_idx_q    <= alu_r[IDX_BITS-1:0];
					res_status_q <= ST_INDEX;
					rp_q         <= rp_q + COUNT_BITS'(1);
					state_q      <= S_EMIT;
				end

				// Hand the result to the output register once it is free.
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_slot_q   <= count_q;
						out_left_q   <= res_left_q;
						out_right_q  <= res_right_q;
						out_axis_q   <= axis_q;
						out_idx_q    <= res_idx_q;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The partition pointers stay ordered inside the loaded range.
	`ASSERT_NEVER(a_ptr_order, ((state_q == S_P_CHK) || (state_q == S_P_EVAL) || (state_q == S_P_SWAP)) && ((i_q > j_q) || (j_q > count_q)), "partition pointers out of order")

	// A finished load leaves a nonempty node in the loading phase.
	`ASSERT_CLK(a_load_count, (state_q == S_L_CMP) |=> ((count_q != '0) && !phase_q), "load did not advance the node")

	// A read only fetches a slot that holds a loaded triangle.
	`ASSERT_CLK(a_read_range, (state_q == S_R_IDX) |-> (phase_q && (rp_q < count_q)), "read past the loaded triangles")

endmodule

### bench/bvh_midpoint_checker.sv
module bvh_midpoint_checker import bvhmp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic [COORD_BITS-1:0]    ax,
	input  logic [COORD_BITS-1:0]    ay,
	input  logic [COORD_BITS-1:0]    az,
	input  logic [COORD_BITS-1:0]    bx,
	input  logic [COORD_BITS-1:0]    by_coord,
	input  logic [COORD_BITS-1:0]    bz,
	input  logic [COORD_BITS-1:0]    cx,
	input  logic [COORD_BITS-1:0]    cy,
	input  logic [COORD_BITS-1:0]    cz,

	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [2:0]               status,
	input  logic [COUNT_BITS-1:0]    slot_count,
	input  logic [COUNT_BITS-1:0]    left_count,
	input  logic [COUNT_BITS-1:0]    right_count,
	input  logic [1:0]               axis,
	input  logic [IDX_BITS-1:0]      tri_index,

	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [REG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]      cfg_data,

	output int                       fail_count,
	output int                       waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	// Nine coordinates of one triangle: A xyz, B xyz, C xyz from index 0 up.
	typedef logic [8:0][COORD_BITS-1:0] vertex_set_t;

	typedef struct {
		logic [2:0]            status;
		logic [COUNT_BITS-1:0] slots;
		logic [COUNT_BITS-1:0] left_n;
		logic [COUNT_BITS-1:0] right_n;
		logic [1:0]            axis_sel;
		logic [IDX_BITS-1:0]   index;
	} node_result_t;

	// Shadow copy of the configuration registers.
	logic signed [COORD_BITS-1:0] lo_bound [3];
	logic signed [COORD_BITS-1:0] hi_bound [3];
	logic signed [LEVEL_BITS-1:0] depth_left;
	logic [BASE_BITS-1:0]         base_slot;

	// Shadow copy of the node being loaded, partitioned and read back.
	logic [SLOT_BITS-1:0] slot_order [MAX_TRIANGLES];
	logic                 slot_left  [MAX_TRIANGLES];
	int unsigned          node_count;
	int unsigned          read_pos;
	logic                 reading;

	node_result_t pending_results [$];

	// Longest axis of the current bounds; ties fall toward the later axis.
	function automatic logic [1:0] longest_axis();
		longint span [3];
		for (int k = 0; k < 3; k++)
			span[k] = longint'(hi_bound[k]) - longint'(lo_bound[k]);
		if (span[0] > span[1])
			return (span[0] > span[2]) ? AXIS_X : AXIS_Z;
		return (span[1] > span[2]) ? AXIS_Y : AXIS_Z;
	endfunction

	// Applies one accepted item to the shadow node and returns its result.
	function automatic node_result_t split_node(logic [1:0] op, vertex_set_t vs);
		node_result_t r;
		int           a;
		longint       centroid3;
		longint       bound_sum;
		int unsigned  front;
		int unsigned  back;
		logic [SLOT_BITS-1:0] held_slot;
		logic         held_side;

		r = '{default: '0};
		r.status = ST_REJECTED;
		r.axis_sel = longest_axis();
		a = int'(r.axis_sel);

		case (op)
			OP_LOAD: begin
				// A load after a partition starts a fresh node.
				if (reading) begin
					node_count = 0;
					read_pos = 0;
					reading = 1'b0;
				end
				if (node_count < MAX_TRIANGLES) begin
					centroid3 = longint'($signed(vs[a])) + longint'($signed(vs[3 + a]))
						+ longint'($signed(vs[6 + a]));
					bound_sum = longint'(lo_bound[a]) + longint'(hi_bound[a]);
					slot_order[node_count] = SLOT_BITS'(node_count);
					slot_left[node_count] = (2 * centroid3 < 3 * bound_sum);
					node_count++;
					r.status = ST_LOADED;
				end
			end
			OP_PARTITION: begin
				if (depth_left <= 0) begin
					r.status = ST_NO_DEPTH;
				end else if (node_count <= 2) begin
					r.status = ST_TOO_FEW;
				end else begin
					// Left entries stay in front; right ones are swapped to the back.
					front = 0;
					back = node_count;
					while (front < back) begin
						if (slot_left[front]) begin
							front++;
						end else begin
							held_slot = slot_order[front];
							held_side = slot_left[front];
							slot_order[front] = slot_order[back - 1];
							slot_left[front] = slot_left[back - 1];
							slot_order[back - 1] = held_slot;
							slot_left[back - 1] = held_side;
							back--;
						end
					end
					r.left_n = COUNT_BITS'(front);
					r.right_n = COUNT_BITS'(node_count - front);
					r.status = (front == 0 || front == node_count) ? ST_ONE_SIDE : ST_SPLIT;
				end
				reading = 1'b1;
				read_pos = 0;
			end
			OP_READ: begin
				if (reading && read_pos < node_count) begin
					r.index = IDX_BITS'(base_slot) + IDX_BITS'(slot_order[read_pos]);
					read_pos++;
					r.status = ST_INDEX;
				end
			end
			default: ;
		endcase

		r.slots = COUNT_BITS'(node_count);
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		node_result_t want;
		if (!arst_n) begin
			lo_bound = '{default: '0};
			hi_bound = '{default: '0};
			depth_left = '0;
			base_slot = '0;
			node_count = 0;
			read_pos = 0;
			reading = 1'b0;
			pending_results.delete();
			waiting = 0;
		end else begin
			// Register writes only come while the block is idle.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_X:  lo_bound[0] = cfg_data;
					REG_MIN_Y:  lo_bound[1] = cfg_data;
					REG_MIN_Z:  lo_bound[2] = cfg_data;
					REG_MAX_X:  hi_bound[0] = cfg_data;
					REG_MAX_Y:  hi_bound[1] = cfg_data;
					REG_MAX_Z:  hi_bound[2] = cfg_data;
					REG_LEVELS: depth_left = cfg_data[LEVEL_BITS-1:0];
					REG_BASE:   base_slot = cfg_data[BASE_BITS-1:0];
					default: ;
				endcase
			end

			// Each result beat is matched against the oldest outstanding item.
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no item outstanding: status %0d", status);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", want.status, status);
					check_field("slot_count", want.slots, slot_count);
					check_field("left_count", want.left_n, left_count);
					check_field("right_count", want.right_n, right_count);
					check_field("axis", want.axis_sel, axis);
					check_field("tri_index", want.index, tri_index);
				end
			end

			if (in_valid && in_ready)
				pending_results.push_back(split_node(operation,
					{cz, cy, cx, bz, by_coord, bx, az, ay, ax}));

			waiting = pending_results.size();
		end
	end

endmodule

### bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bvhmp_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         ITEM_TARGET  = 1150;
	localparam int         IDLE_CYCLES  = 20;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         FILL_READS   = 16;
	localparam longint     COORD_MAX    = 64'sd2147483647;
	localparam longint     COORD_MIN    = -64'sd2147483648;

	typedef logic [COORD_BITS-1:0]       coord_t;
	typedef logic [8:0][COORD_BITS-1:0]  vertex_set_t;

	logic                     clk = 1'b0;
	logic                     arst_n;

	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               operation;
	logic [COORD_BITS-1:0]    ax;
	logic [COORD_BITS-1:0]    ay;
	logic [COORD_BITS-1:0]    az;
	logic [COORD_BITS-1:0]    bx;
	logic [COORD_BITS-1:0]    by_coord;
	logic [COORD_BITS-1:0]    bz;
	logic [COORD_BITS-1:0]    cx;
	logic [COORD_BITS-1:0]    cy;
	logic [COORD_BITS-1:0]    cz;

	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               status;
	logic [COUNT_BITS-1:0]    slot_count;
	logic [COUNT_BITS-1:0]    left_count;
	logic [COUNT_BITS-1:0]    right_count;
	logic [1:0]               axis;
	logic [IDX_BITS-1:0]      tri_index;

	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [REG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_BITS-1:0]      cfg_data;

	int                       fail_count;
	int                       waiting;

	// Stimulus-side view of the bounds, used to aim coordinates at the midpoint.
	longint bnd_lo [3];
	longint bnd_hi [3];
	int     items_sent;
	logic   calm = 1'b0;
	int     skew;

	bvh_midpoint_partition_top dut (.*);

	bvh_midpoint_checker checker_i (.*);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic vertex_set_t random_set();
		vertex_set_t vs;
		for (int i = 0; i < 9; i++)
			vs[i] = $urandom;
		return vs;
	endfunction

	// Sets the x coordinates of A, B and C; every other coordinate gets fill.
	function automatic vertex_set_t x_set(coord_t x0, coord_t x1, coord_t x2, coord_t fill);
		vertex_set_t vs;
		vs = {9{fill}};
		vs[0] = x0;
		vs[3] = x1;
		vs[6] = x2;
		return vs;
	endfunction

	// A coordinate around the midpoint of one axis, pushed to one side by skew.
	function automatic coord_t coord_near(int a);
		longint mid;
		longint span;
		longint off;
		longint v;
		mid = (bnd_lo[a] + bnd_hi[a]) >>> 1;
		span = ((bnd_hi[a] > bnd_lo[a]) ? bnd_hi[a] - bnd_lo[a] : bnd_lo[a] - bnd_hi[a]) + 4;
		off = longint'({$urandom, $urandom} >> 1) % span;
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				case (skew)
					1: v = mid - off - 1;
					2: v = mid + off;
					default: v = mid + off - span / 2;
				endcase
			end
		endcase
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return coord_t'(v);
	endfunction

	// One input beat, after a random gap unless the sender is in a calm stretch.
	task automatic send(input logic [1:0] op, input vertex_set_t vs);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		operation = op;
		ax = vs[0];
		ay = vs[1];
		az = vs[2];
		bx = vs[3];
		by_coord = vs[4];
		bz = vs[5];
		cx = vs[6];
		cy = vs[7];
		cz = vs[8];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic load_tri();
		vertex_set_t vs;
		for (int i = 0; i < 9; i++)
			vs[i] = coord_near(i % 3);
		send(OP_LOAD, vs);
	endtask

	// Stop sending and let every outstanding result come back.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (IDLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			REG_MIN_X: bnd_lo[0] = longint'($signed(data));
			REG_MIN_Y: bnd_lo[1] = longint'($signed(data));
			REG_MIN_Z: bnd_lo[2] = longint'($signed(data));
			REG_MAX_X: bnd_hi[0] = longint'($signed(data));
			REG_MAX_Y: bnd_hi[1] = longint'($signed(data));
			REG_MAX_Z: bnd_hi[2] = longint'($signed(data));
			default: ;
		endcase
	endtask

	// New bounds, and now and then a new depth and base index.
	task automatic reconfigure();
		longint lo [3];
		longint hi [3];
		longint len_shared;
		int     scheme;
		int     wide;
		int     halved;
		int     lvl;
		scheme = $urandom_range(0, 3);
		wide = $urandom_range(0, 2);
		halved = $urandom_range(0, 3);
		len_shared = $urandom_range(0, 1 << 24);
		for (int a = 0; a < 3; a++) begin
			case (scheme)
				// One axis spans the whole coordinate range.
				0: begin
					if (a == wide) begin
						lo[a] = COORD_MIN;
						hi[a] = COORD_MAX;
					end else begin
						lo[a] = longint'($signed($urandom)) >>> 4;
						hi[a] = lo[a] + $urandom_range(0, 1 << 20);
					end
				end
				// Equal spans on two or three axes exercise the tie rule.
				1: begin
					lo[a] = longint'($signed($urandom)) >>> 8;
					hi[a] = lo[a] + ((a == halved) ? len_shared / 2 : len_shared);
				end
				// Arbitrary values, inverted bounds included.
				2: begin
					lo[a] = longint'($signed($urandom));
					hi[a] = longint'($signed($urandom));
				end
				default: begin
					lo[a] = longint'($signed($urandom)) >>> 12;
					hi[a] = lo[a] + $urandom_range(0, 1 << (8 + 4 * a + $urandom_range(0, 3)));
				end
			endcase
		end
		write_reg(REG_MIN_X, CFG_BITS'(lo[0]));
		write_reg(REG_MAX_X, CFG_BITS'(hi[0]));
		write_reg(REG_MIN_Y, CFG_BITS'(lo[1]));
		write_reg(REG_MAX_Y, CFG_BITS'(hi[1]));
		write_reg(REG_MIN_Z, CFG_BITS'(lo[2]));
		write_reg(REG_MAX_Z, CFG_BITS'(hi[2]));
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 9))
				0: lvl = 0;
				1: lvl = 0 - int'($urandom_range(1, 255));
				2: lvl = 255;
				3: lvl = -255;
				default: lvl = $urandom_range(1, 254);
			endcase
			write_reg(REG_LEVELS, CFG_BITS'(lvl));
		end
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 4))
				0: write_reg(REG_BASE, '0);
				1: write_reg(REG_BASE, 32'h000F_FFFF);
				default: write_reg(REG_BASE, CFG_BITS'($urandom_range(0, 20'hF_FFFF)));
			endcase
		end
	endtask

	// Result side: random stalls with bursts of readiness in between.
	initial begin
		int stall;
		out_ready = 1'b1;
		forever begin
			stall = calm ? 0 : pick_gap();
			repeat (stall) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	initial begin
		int n;
		int reads;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_LOAD;
		{ax, ay, az, bx, by_coord, bz, cx, cy, cz} = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_X;
		cfg_data = '0;
		calm = 1'b0;
		skew = 0;
		items_sent = 0;
		bnd_lo = '{default: 0};
		bnd_hi = '{default: 0};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: rejected reads and operation code, then a stop for depth.
		send(OP_READ, random_set());
		send(OP_UNUSED, random_set());
		send(OP_PARTITION, random_set());
		send(OP_READ, random_set());

		// Widest x span, deepest level, top base index.
		settle();
		write_reg(REG_MIN_X, 32'h8000_0000);
		write_reg(REG_MAX_X, 32'h7FFF_FFFF);
		write_reg(REG_LEVELS, 32'd255);
		write_reg(REG_BASE, 32'h000F_FFFF);
		send(OP_LOAD, x_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send(OP_LOAD, x_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
		// With min+max = -1, a vertex sum of -1 is not below the midpoint; -2 is.
		send(OP_LOAD, x_set(32'hFFFF_FFFF, '0, '0, 32'h5555_5555));
		send(OP_LOAD, x_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 32'hAAAA_AAAA));
		send(OP_PARTITION, random_set());
		repeat (5) send(OP_READ, random_set());
		// Partition again while reading, then a load that opens a new node.
		send(OP_PARTITION, random_set());
		send(OP_READ, random_set());
		repeat (3) send(OP_LOAD, x_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom));
		send(OP_PARTITION, random_set());

		// Negative depth stops the split.
		settle();
		write_reg(REG_LEVELS, 32'hFFFF_FF01);
		repeat (3) send(OP_LOAD, random_set());
		send(OP_PARTITION, random_set());

		// Two triangles are too few to split.
		settle();
		write_reg(REG_LEVELS, 32'd1);
		repeat (2) send(OP_LOAD, random_set());
		send(OP_PARTITION, random_set());

		// Fill the store, overflow it, split it and read the front entries back.
		settle();
		reconfigure();
		write_reg(REG_LEVELS, 32'd7);
		repeat (MAX_TRIANGLES + 2) load_tri();
		send(OP_PARTITION, random_set());
		repeat (FILL_READS) send(OP_READ, random_set());

		// Random nodes: loads, a partition, then reads, with some noise mixed in.
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 5) == 0) begin
				settle();
				reconfigure();
			end
			calm = ($urandom_range(0, 5) == 0);
			skew = ($urandom_range(0, 7) < 6) ? 0 : $urandom_range(1, 2);
			case ($urandom_range(0, 19))
				0, 1: n = $urandom_range(0, 2);
				2, 3: n = $urandom_range(13, 48);
				default: n = $urandom_range(3, 12);
			endcase
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 19) == 0)
					send($urandom_range(0, 1) ? OP_UNUSED : OP_READ, random_set());
				load_tri();
			end
			send(OP_PARTITION, random_set());
			if ($urandom_range(0, 5) == 0)
				send(OP_PARTITION, random_set());
			case ($urandom_range(0, 9))
				0, 1: reads = $urandom_range(0, n);
				2, 3: reads = n + $urandom_range(1, 2);
				default: reads = n;
			endcase
			for (int k = 0; k < reads; k++) begin
				if ($urandom_range(0, 29) == 0)
					send(OP_PARTITION, random_set());
				send(OP_READ, random_set());
			end
		end

		calm = 1'b0;
		@(negedge clk);
		in_valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/bvhmp_pkg.sv
sv/bvh_midpoint_partition_top.sv
bench/bvh_midpoint_checker.sv
bench/tb.sv
